### rtl/pfe_pkg.sv
// shared constants, types and state codes for the postfix expression evaluator
`default_nettype none
package pfe_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ITER_W      = $clog2(DATA_W + 1);
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    localparam logic [SYM_W-1:0] SYM_END   = 8'h00;
    localparam logic [SYM_W-1:0] SYM_DIG0  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_DIG9  = 8'h39;
    localparam logic [SYM_W-1:0] SYM_ADD   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_SUB   = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_OPER,
        FSM_DIV,
        FSM_EMIT
    } fsm_t;

endpackage
`default_nettype wire

### rtl/pfe_divider.sv
// iterative signed divider, truncating toward zero, one quotient bit per cycle
`default_nettype none
module pfe_divider (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire pfe_pkg::data_t dividend,
    input  wire pfe_pkg::data_t divisor,
    output logic               done,
    output pfe_pkg::data_t     quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pfe_pkg::ITER_W-1:0]    iter_reg, iter_next;
    pfe_pkg::data_t                rem_reg, rem_next;
    pfe_pkg::data_t                quo_reg, quo_next;
    pfe_pkg::data_t                dsr_reg, dsr_next;
    logic                          neg_reg, neg_next;
    logic [pfe_pkg::DATA_W:0]      shifted;
    logic [pfe_pkg::DATA_W:0]      diff;

    assign shifted = {rem_reg, quo_reg[pfe_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = pfe_pkg::ITER_W'(pfe_pkg::DATA_W);
            rem_next  = '0;
            quo_next  = dividend[pfe_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dsr_next  = divisor[pfe_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[pfe_pkg::DATA_W-1] ^ divisor[pfe_pkg::DATA_W-1];
        end else if (busy_reg) begin
            rem_next  = diff[pfe_pkg::DATA_W] ? shifted[pfe_pkg::DATA_W-1:0]
                                              : diff[pfe_pkg::DATA_W-1:0];
            quo_next  = {quo_reg[pfe_pkg::DATA_W-2:0], ~diff[pfe_pkg::DATA_W]};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == pfe_pkg::ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule
`default_nettype wire

### rtl/postfix_expression_evaluator_unit.sv
// top level: operand stack memory, stack sequencer and result register
//
// channel  dir  tdata                         tuser
// s_       in   [7:0] symbol                  -
// m_       out  [31:0] value (signed)         [1:0] status
//
// digits and ignored symbols are handled in the idle state; + - * read the stack, then write back
// / reads the stack, then runs through the bit-serial divider; a zero byte reads the top of stack
// and then waits for the result register to free up
// reset empties the stack and clears the error; the stack memory itself is not cleared
// one symbol is in work at a time; a waiting result does not block digits or operators
`default_nettype none
module postfix_expression_evaluator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic [1:0]       m_tuser    // [1:0] status
);

    pfe_pkg::fsm_t                     state_reg, state_next;
    logic [pfe_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [pfe_pkg::STATUS_W-1:0]      err_reg, err_next;
    logic [pfe_pkg::SYM_W-1:0]         op_reg, op_next;
    logic [pfe_pkg::STATUS_W-1:0]      emit_status_reg, emit_status_next;
    logic                              emit_mem_reg, emit_mem_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    pfe_pkg::data_t                    m_value_reg, m_value_next;
    logic [pfe_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;

    pfe_pkg::data_t                    stack_mem [pfe_pkg::STACK_DEPTH];
    pfe_pkg::data_t                    rd_a_reg, rd_b_reg;
    logic                              rd_en;
    logic                              wr_en;
    logic [pfe_pkg::PTR_W-1:0]         wr_addr;
    pfe_pkg::data_t                    wr_data;
    logic [pfe_pkg::PTR_W-1:0]         top_addr, next_addr;

    logic                              accept;
    logic                              is_digit, is_oper;
    logic                              out_free;
    logic                              div_start, div_done;
    pfe_pkg::data_t                    div_quo;
    pfe_pkg::data_t                    alu_res;

    assign accept    = s_tvalid && s_tready;
    assign is_digit  = (s_tdata >= pfe_pkg::SYM_DIG0) && (s_tdata <= pfe_pkg::SYM_DIG9);
    assign is_oper   = (s_tdata == pfe_pkg::SYM_ADD) || (s_tdata == pfe_pkg::SYM_SUB) ||
                       (s_tdata == pfe_pkg::SYM_MUL) || (s_tdata == pfe_pkg::SYM_DIV);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign top_addr  = pfe_pkg::PTR_W'(cnt_reg - 1'b1);
    assign next_addr = pfe_pkg::PTR_W'(cnt_reg - 2'd2);

    // rd_a is the right operand (top), rd_b the left one
    always_comb begin
        case (op_reg)
            pfe_pkg::SYM_ADD: alu_res = rd_b_reg + rd_a_reg;
            pfe_pkg::SYM_SUB: alu_res = rd_b_reg - rd_a_reg;
            pfe_pkg::SYM_MUL: alu_res = rd_b_reg * rd_a_reg;
            default:          alu_res = div_quo;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfe_pkg::FSM_IDLE: begin
                if (accept) begin
                    if (s_tdata == pfe_pkg::SYM_END) begin
                        state_next = pfe_pkg::FSM_EMIT;
                    end else if (err_reg == pfe_pkg::ST_OK && is_oper &&
                                 cnt_reg >= pfe_pkg::CNT_W'(2)) begin
                        state_next = pfe_pkg::FSM_OPER;
                    end
                end
            end
            pfe_pkg::FSM_OPER: begin
                if (op_reg == pfe_pkg::SYM_DIV && rd_a_reg != '0) begin
                    state_next = pfe_pkg::FSM_DIV;
                end else begin
                    state_next = pfe_pkg::FSM_IDLE;
                end
            end
            pfe_pkg::FSM_DIV: begin
                if (div_done) begin
                    state_next = pfe_pkg::FSM_IDLE;
                end
            end
            pfe_pkg::FSM_EMIT: begin
                if (out_free) begin
                    state_next = pfe_pkg::FSM_IDLE;
                end
            end
            default: state_next = pfe_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        cnt_next         = cnt_reg;
        err_next         = err_reg;
        op_next          = op_reg;
        emit_status_next = emit_status_reg;
        emit_mem_next    = emit_mem_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_value_next     = m_value_reg;
        m_status_next    = m_status_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = next_addr;
        wr_data          = alu_res;
        div_start        = 1'b0;
        s_tready         = 1'b0;
        case (state_reg)
            pfe_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    rd_en   = 1'b1;
                    op_next = s_tdata;
                    if (s_tdata == pfe_pkg::SYM_END) begin
                        // top of stack is read now, count and error clear for the next expression
                        emit_mem_next = 1'b0;
                        if (err_reg != pfe_pkg::ST_OK) begin
                            emit_status_next = err_reg;
                        end else if (cnt_reg == '0) begin
                            emit_status_next = pfe_pkg::ST_UNDER;
                        end else begin
                            emit_status_next = pfe_pkg::ST_OK;
                            emit_mem_next    = 1'b1;
                        end
                        cnt_next = '0;
                        err_next = pfe_pkg::ST_OK;
                    end else if (err_reg == pfe_pkg::ST_OK) begin
                        if (is_digit) begin
                            if (cnt_reg >= pfe_pkg::DEPTH_CNT) begin
                                err_next = pfe_pkg::ST_OVER;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = cnt_reg[pfe_pkg::PTR_W-1:0];
                                wr_data  = {{(pfe_pkg::DATA_W - pfe_pkg::SYM_W){1'b0}},
                                            s_tdata - pfe_pkg::SYM_DIG0};
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end else if (is_oper && cnt_reg < pfe_pkg::CNT_W'(2)) begin
                            err_next = pfe_pkg::ST_UNDER;
                        end
                    end
                end
            end
            pfe_pkg::FSM_OPER: begin
                if (op_reg == pfe_pkg::SYM_DIV) begin
                    if (rd_a_reg == '0) begin
                        err_next = pfe_pkg::ST_DIVZERO;
                        cnt_next = cnt_reg - 2'd2;
                    end else begin
                        div_start = 1'b1;
                    end
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            pfe_pkg::FSM_DIV: begin
                if (div_done) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            pfe_pkg::FSM_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = emit_mem_reg ? rd_a_reg : '0;
                    m_status_next = emit_status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= stack_mem[top_addr];
            rd_b_reg <= stack_mem[next_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pfe_pkg::FSM_IDLE;
            cnt_reg      <= '0;
            err_reg      <= pfe_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg          <= op_next;
        emit_status_reg <= emit_status_next;
        emit_mem_reg    <= emit_mem_next;
        m_value_reg     <= m_value_next;
        m_status_reg    <= m_status_next;
    end

    pfe_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_b_reg),
        .divisor  (rd_a_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

endmodule
`default_nettype wire

### rtl/pfe_checker.sv
// port-level checks for the postfix expression evaluator, bound to the top level
`default_nettype none
module pfe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != pfe_pkg::ST_OK |-> m_tdata == '0)
        else $error("error result with nonzero value");

    // end of expression holds off the input while the result is formed
    a_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata == pfe_pkg::SYM_END |=> !s_tready)
        else $error("input taken during end of expression");

    // a digit does not stall the input: it is ready again in the next cycle
    a_digit_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata >= pfe_pkg::SYM_DIG0 &&
        s_tdata <= pfe_pkg::SYM_DIG9 |=> s_tready)
        else $error("digit stalled the input");

endmodule

bind postfix_expression_evaluator_unit pfe_checker u_pfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
